FILE: sv/temst_pkg.sv
// Package with types and constants shared by the message slot table.
`timescale 1ns / 1ps
package temst_pkg;

  localparam int unsigned DefaultSlots = 16;

  typedef enum logic [2:0] {
    OP_ADD_UNREAD = 3'd0,
    OP_ADD_STORE  = 3'd1,
    OP_MARK_READ  = 3'd2,
    OP_MARK_DELIV = 3'd3,
    OP_DELETE     = 3'd4,
    OP_LOOKUP     = 3'd5,
    OP_RSVD6      = 3'd6,
    OP_RSVD7      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    T_EMPTY     = 3'd0,
    T_UNREAD    = 3'd1,
    T_READ      = 3'd2,
    T_STORE     = 3'd3,
    T_DELIVERED = 3'd4
  } slot_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_WRONG     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_COUNT,
    S_OUT
  } fsm_e;

  // Per-slot scan record handed from the sequencer's scan unit.
  typedef struct packed {
    logic       occupied;
    logic       unread;
    logic       id_match;
    logic       is_empty;
    slot_type_e stype;
    logic [15:0] sid;
  } scan_t;

endpackage

FILE: sv/tiered_evicting_message_slot_table.sv
// Top level of the tiered evicting message slot table.
`timescale 1ns / 1ps
// Each command word walks the slot table one slot per cycle through a single
// compare unit: a scan pass finds a match, the first empty slot and the
// lowest id of each eviction tier, the apply state makes the change, a second
// pass recounts the live and unread slots, and its last step loads the result
// register. The input is not ready until the result word has been taken.
module tiered_evicting_message_slot_table
  import temst_pkg::*;
#(
  parameter int unsigned SLOTS = DefaultSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[2:0], entry_id[18:3], freq_hz[50:19], snr_db[58:51], time_of_day[75:59]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], slot[5:2], result_id[21:6], result_type[24:22],
  // result_freq[56:25], result_snr[64:57], result_time[81:65],
  // evicted[82], evicted_type[85:83], live_count[90:86], unread_count[95:91]
  output logic [95:0] m_axis_tdata
);
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  slot_type_e   type_q [SLOTS];
  logic [15:0]  id_q   [SLOTS];
  logic [31:0]  freq_m [SLOTS];
  logic [7:0]   snr_m  [SLOTS];
  logic [16:0]  time_m [SLOTS];

  logic [7:0]   snr_na_q;
  logic [15:0]  next_id_q;
  fsm_e         st_q, st_d;
  logic [IW:0]  idx_q;
  logic [IW-1:0] ix;
  logic [79:0]  in_q;
  op_e          op;
  logic [15:0]  tid;

  logic         match_v_q, empty_v_q;
  logic [IW-1:0] match_s_q, empty_s_q;
  logic [3:0]   tier_v_q;
  logic [IW-1:0] tier_s_q [4];
  logic [15:0]  tier_id_q [4];
  logic [CW-1:0] tot_q, unr_q;
  logic [95:0]  out_q;

  // Result fields held from the apply step.
  logic [1:0]   r_status_q;
  logic [IW-1:0] r_slot_q;
  logic [15:0]  r_id_q;
  logic [2:0]   r_type_q;
  logic [31:0]  r_freq_q;
  logic [7:0]   r_snr_q;
  logic [16:0]  r_time_q;
  logic         r_ev_q;
  logic [2:0]   r_evt_q;

  scan_t sc;

  assign ix  = idx_q[IW-1:0];
  assign op  = op_e'(in_q[2:0]);
  assign tid = in_q[18:3];

  temst_scan u_scan (
    .stype_i     (type_q[ix]),
    .sid_i       (id_q[ix]),
    .target_id_i (tid),
    .scan_o      (sc)
  );

  assign cfg_ready_o   = (st_q == S_IDLE);
  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = (st_q == S_OUT);
  assign m_axis_tdata  = out_q;

  logic last;
  assign last = (idx_q == (IW + 1)'(SLOTS - 1));

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:  if (s_axis_tvalid) st_d = S_SCAN;
      S_SCAN:  if (last) st_d = S_APPLY;
      S_APPLY: st_d = S_COUNT;
      S_COUNT: if (last) st_d = S_OUT;
      S_OUT:   if (m_axis_tready) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // Tier rank of a slot type in eviction order: delivered, read, store, unread.
  function automatic logic [2:0] tier_of(slot_type_e t);
    case (t)
      T_DELIVERED: tier_of = 3'd0;
      T_READ:      tier_of = 3'd1;
      T_STORE:     tier_of = 3'd2;
      T_UNREAD:    tier_of = 3'd3;
      default:     tier_of = 3'd4;
    endcase
  endfunction

  logic [2:0] tr;
  assign tr = tier_of(sc.stype);

  // Victim choice from the scan summary.
  logic         add_op;
  logic [IW-1:0] vic;
  always_comb begin
    add_op = (op == OP_ADD_UNREAD) || (op == OP_ADD_STORE);
    if (empty_v_q) vic = empty_s_q;
    else if (tier_v_q[0]) vic = tier_s_q[0];
    else if (tier_v_q[1]) vic = tier_s_q[1];
    else if (tier_v_q[2]) vic = tier_s_q[2];
    else if (tier_v_q[3]) vic = tier_s_q[3];
    else vic = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      idx_q     <= '0;
      snr_na_q  <= 8'h80;
      next_id_q <= 16'd1;
      for (int i = 0; i < SLOTS; i++) begin
        type_q[i] <= T_EMPTY;
        id_q[i]   <= '0;
      end
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) snr_na_q <= cfg_data_i;
      case (st_q)
        S_SCAN, S_COUNT: idx_q <= last ? '0 : idx_q + 1'b1;
        default: idx_q <= '0;
      endcase
      if (st_q == S_APPLY) begin
        if (add_op) begin
          id_q[vic]   <= next_id_q;
          type_q[vic] <= (op == OP_ADD_UNREAD) ? T_UNREAD : T_STORE;
          next_id_q   <= (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1;
        end else if (match_v_q) begin
          case (op)
            OP_MARK_READ:
              if (type_q[match_s_q] == T_UNREAD) type_q[match_s_q] <= T_READ;
            OP_MARK_DELIV:
              if (type_q[match_s_q] == T_STORE) type_q[match_s_q] <= T_DELIVERED;
            OP_DELETE: begin
              type_q[match_s_q] <= T_EMPTY;
              id_q[match_s_q]   <= '0;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Input capture, payload stores, scan and count bookkeeping, and result fields.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_q <= s_axis_tdata;
    case (st_q)
      S_SCAN: begin
        if (idx_q == '0) begin
          match_v_q <= sc.id_match;
          match_s_q <= ix;
          empty_v_q <= sc.is_empty;
          empty_s_q <= ix;
          for (int k = 0; k < 4; k++) begin
            tier_v_q[k]  <= (tr == 3'(k)) && (sc.sid != 16'hFFFF);
            tier_id_q[k] <= (tr == 3'(k)) ? sc.sid : 16'hFFFF;
            tier_s_q[k]  <= ix;
          end
        end else begin
          if (sc.id_match && !match_v_q) begin
            match_v_q <= 1'b1;
            match_s_q <= ix;
          end
          if (sc.is_empty && !empty_v_q) begin
            empty_v_q <= 1'b1;
            empty_s_q <= ix;
          end
          for (int k = 0; k < 4; k++) begin
            if ((tr == 3'(k)) && (sc.sid < tier_id_q[k])) begin
              tier_v_q[k]  <= 1'b1;
              tier_id_q[k] <= sc.sid;
              tier_s_q[k]  <= ix;
            end
          end
        end
      end
      S_APPLY: begin
        r_status_q <= ST_OK;
        r_slot_q   <= '0;
        r_id_q     <= '0;
        r_type_q   <= T_EMPTY;
        r_freq_q   <= '0;
        r_snr_q    <= '0;
        r_time_q   <= '0;
        r_ev_q     <= 1'b0;
        r_evt_q    <= T_EMPTY;
        if (add_op) begin
          r_slot_q <= vic;
          r_id_q   <= next_id_q;
          r_type_q <= (op == OP_ADD_UNREAD) ? T_UNREAD : T_STORE;
          r_ev_q   <= (type_q[vic] != T_EMPTY);
          r_evt_q  <= type_q[vic];
          time_m[vic] <= in_q[75:59];
          freq_m[vic] <= (op == OP_ADD_UNREAD) ? in_q[50:19] : 32'd0;
          snr_m[vic]  <= (op == OP_ADD_UNREAD) ? in_q[58:51] : snr_na_q;
        end else if (op == OP_MARK_READ || op == OP_MARK_DELIV ||
                     op == OP_DELETE || op == OP_LOOKUP) begin
          if (!match_v_q) begin
            r_status_q <= ST_NOT_FOUND;
          end else begin
            r_slot_q <= match_s_q;
            r_id_q   <= id_q[match_s_q];
            r_type_q <= type_q[match_s_q];
            case (op)
              OP_MARK_READ:
                if (type_q[match_s_q] == T_UNREAD) r_type_q <= T_READ;
                else r_status_q <= ST_WRONG;
              OP_MARK_DELIV:
                if (type_q[match_s_q] == T_STORE) r_type_q <= T_DELIVERED;
                else r_status_q <= ST_WRONG;
              OP_DELETE: r_type_q <= T_EMPTY;
              default: begin
                r_freq_q <= freq_m[match_s_q];
                r_snr_q  <= snr_m[match_s_q];
                r_time_q <= time_m[match_s_q];
              end
            endcase
          end
        end
      end
      S_COUNT: begin
        if (idx_q == '0) begin
          tot_q <= CW'(sc.occupied);
          unr_q <= CW'(sc.unread);
        end else begin
          tot_q <= tot_q + CW'(sc.occupied);
          unr_q <= unr_q + CW'(sc.unread);
        end
        if (last) begin
          out_q <= {5'(unr_q + CW'(sc.unread)), 5'(tot_q + CW'(sc.occupied)),
                    r_evt_q, r_ev_q, r_time_q, r_snr_q, r_freq_q, r_type_q,
                    r_id_q, 4'(r_slot_q), r_status_q};
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: sv/temst_scan.sv
// Shared compare unit: examines one slot per cycle for the sequencer.
`timescale 1ns / 1ps
module temst_scan
  import temst_pkg::*;
(
  input  slot_type_e  stype_i,
  input  logic [15:0] sid_i,
  input  logic [15:0] target_id_i,
  output scan_t       scan_o
);
  always_comb begin
    scan_o.is_empty = (stype_i == T_EMPTY);
    scan_o.occupied = (stype_i != T_EMPTY);
    scan_o.unread   = (stype_i == T_UNREAD);
    scan_o.id_match = (stype_i != T_EMPTY) && (sid_i == target_id_i) && (target_id_i != 16'd0);
    scan_o.stype    = stype_i;
    scan_o.sid      = sid_i;
  end
endmodule
